// ===== rtl/core/cfsg_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfsg_pkg
// Shared types and constants for the coil firing sequencer.
// ---------------------------------------------------------------------------
package cfsg_pkg;

   localparam int NUM_GATES   = 4;
   localparam int NUM_SENSORS = 5;
   localparam int NUM_REGS    = 6;

   localparam int REG_W   = 16;
   localparam int TIME_W  = 32;
   localparam int SPEED_W = 16;
   localparam int NUM_W   = 26;   // spacing_um * 1000 fits in 26 bits
   localparam int ADDR_W  = 5;
   localparam int IDX_W   = 3;
   localparam int GIDX_W  = 2;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 80;

   // register indexes
   localparam logic [IDX_W-1:0] REG_SPACING_1 = 3'd0;
   localparam logic [IDX_W-1:0] REG_SPACING_2 = 3'd1;
   localparam logic [IDX_W-1:0] REG_SPACING_3 = 3'd2;
   localparam logic [IDX_W-1:0] REG_SPACING_4 = 3'd3;
   localparam logic [IDX_W-1:0] REG_WINDOW    = 3'd4;
   localparam logic [IDX_W-1:0] REG_COOLDOWN  = 3'd5;

   localparam logic [REG_W-1:0] RST_SPACING_1 = 16'd38000;
   localparam logic [REG_W-1:0] RST_SPACING_2 = 16'd38000;
   localparam logic [REG_W-1:0] RST_SPACING_3 = 16'd39500;
   localparam logic [REG_W-1:0] RST_SPACING_4 = 16'd39000;
   localparam logic [REG_W-1:0] RST_WINDOW    = 16'd1000;
   localparam logic [REG_W-1:0] RST_COOLDOWN  = 16'd10000;

   localparam logic [NUM_W-1:0]   UM_TO_MM_SCALE = 26'd1000;
   localparam logic [SPEED_W-1:0] SPEED_MAX      = 16'hFFFF;

   typedef struct packed {
      logic [NUM_GATES-1:0][REG_W-1:0] spacing_um;
      logic [REG_W-1:0]                fire_window_ms;
      logic [REG_W-1:0]                cooldown_ms;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  num;
      logic [TIME_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [SPEED_W-1:0] quot;
   } div_rsp_type;

endpackage

// ===== rtl/core/cfsg_csr.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfsg_csr
// APB-style register file holding gate spacings and firing timings.
// ---------------------------------------------------------------------------
module cfsg_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [cfsg_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready,
   output cfsg_pkg::cfg_type         cfg
);
   import cfsg_pkg::*;

   logic [REG_W-1:0] regs_ff [NUM_REGS];
   logic [IDX_W-1:0] idx;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[REG_SPACING_1] <= RST_SPACING_1;
         regs_ff[REG_SPACING_2] <= RST_SPACING_2;
         regs_ff[REG_SPACING_3] <= RST_SPACING_3;
         regs_ff[REG_SPACING_4] <= RST_SPACING_4;
         regs_ff[REG_WINDOW]    <= RST_WINDOW;
         regs_ff[REG_COOLDOWN]  <= RST_COOLDOWN;
      end else if (wr_en && idx <= REG_COOLDOWN) begin
         regs_ff[idx] <= csr_pwdata[REG_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (idx <= REG_COOLDOWN) begin
         csr_prdata = {16'd0, regs_ff[idx]};
      end
   end

   assign cfg.spacing_um[0]  = regs_ff[REG_SPACING_1];
   assign cfg.spacing_um[1]  = regs_ff[REG_SPACING_2];
   assign cfg.spacing_um[2]  = regs_ff[REG_SPACING_3];
   assign cfg.spacing_um[3]  = regs_ff[REG_SPACING_4];
   assign cfg.fire_window_ms = regs_ff[REG_WINDOW];
   assign cfg.cooldown_ms    = regs_ff[REG_COOLDOWN];

endmodule

// ===== rtl/core/cfsg_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfsg_div
// Shared radix-2 restoring divider with saturation to 16 bits.
// ---------------------------------------------------------------------------
module cfsg_div (
   input  logic                  clock,
   input  logic                  reset,
   input  cfsg_pkg::div_req_type req,
   output cfsg_pkg::div_rsp_type rsp
);
   import cfsg_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [SPEED_W-1:0]   quo_ff, quo_in;
   logic [TIME_W-1:0]    den_ff, den_in;
   logic [TIME_W:0]      trial;
   logic [TIME_W:0]      diff;
   logic                 fits;
   logic                 sat;

   // quotient overflows 16 bits iff num >= den * 2^16
   assign sat   = {22'd0, req.num[NUM_W-1:SPEED_W]} >= req.den;
   assign trial = {rem_ff, quo_ff[SPEED_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (req.start) begin
         cnt_in = 4'd0;
         if (sat) begin
            quo_in  = SPEED_MAX;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = {22'd0, req.num[NUM_W-1:SPEED_W]};
            quo_in  = req.num[SPEED_W-1:0];
            den_in  = req.den;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
         quo_in = {quo_ff[SPEED_W-2:0], fits};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

// ===== rtl/core/coil_firing_sequencer_with_speed_gates.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// coil_firing_sequencer_with_speed_gates
// Arms a firing window on sensor 1, drives one-hot coils and times gates.
// ---------------------------------------------------------------------------
// A sample passes from ST_ARM straight to ST_DONE when sensor 1 reads low,
// as the gates are skipped; otherwise the four gates are walked in ST_GATE.
// Each gate that reports a speed waits in ST_DIV for the shared divider,
// which produces one quotient bit per cycle and serves the gates in turn (a
// saturated speed skips the bit steps); all four gates can report. The
// input is not ready while a sample is in work, but a new sample is taken
// while the previous result still waits in the output register; a finished
// sample holds until that register is free.
module coil_firing_sequencer_with_speed_gates (
   input  logic                            clock,
   input  logic                            reset,
   // tdata: sensor_levels[4:0], time_us[36:5], time_ms[68:37]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cfsg_pkg::REQ_DATA_W-1:0] req_tdata,
   // tdata: coil_drive[4:0], speed_valid[8:5], speed_gate_1[24:9],
   //        speed_gate_2[40:25], speed_gate_3[56:41], speed_gate_4[72:57]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cfsg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cfsg_pkg::ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import cfsg_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ARM  = 3'd1;
   localparam logic [2:0] ST_GATE = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [2:0]               state_ff, state_in;
   logic [GIDX_W-1:0]        gidx_ff, gidx_in;
   logic [NUM_SENSORS-1:0]   lvl_ff, lvl_in;
   logic [TIME_W-1:0]        tus_ff, tus_in;
   logic [TIME_W-1:0]        tms_ff, tms_in;
   logic [TIME_W-1:0]        arm_ff, arm_in;
   logic [TIME_W-1:0]        start_ff [NUM_GATES];
   logic [TIME_W-1:0]        start_in [NUM_GATES];
   logic [NUM_SENSORS-1:0]   coil_ff, coil_in;
   logic [NUM_GATES-1:0]     valid_ff, valid_in;
   logic [SPEED_W-1:0]       spd_ff [NUM_GATES];
   logic [SPEED_W-1:0]       spd_in [NUM_GATES];
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic [TIME_W-1:0]        arm_new;
   logic [TIME_W-1:0]        elapsed_ms;
   logic [NUM_SENSORS-1:0]   low_mask;
   logic [NUM_SENSORS-1:0]   lowest_low;
   logic [NUM_SENSORS-1:0]   lvl_shift;
   logic                     here_low, next_low;
   logic [TIME_W-1:0]        gate_start;
   logic [TIME_W-1:0]        gate_el;
   logic                     out_free;

   cfsg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cfsg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // arming and window test
   assign arm_new    = (!lvl_ff[0] && arm_ff == '0) ? tms_ff : arm_ff;
   assign elapsed_ms = tms_ff - arm_new;
   assign low_mask   = ~lvl_ff;
   assign lowest_low = low_mask & (~low_mask + 5'd1);

   // current gate
   assign lvl_shift  = lvl_ff >> gidx_ff;
   assign here_low   = !lvl_shift[0];
   assign next_low   = !lvl_shift[1];
   assign gate_start = start_ff[gidx_ff];
   assign gate_el    = tus_ff - gate_start;

   always_comb begin
      state_in     = state_ff;
      gidx_in      = gidx_ff;
      lvl_in       = lvl_ff;
      tus_in       = tus_ff;
      tms_in       = tms_ff;
      arm_in       = arm_ff;
      start_in     = start_ff;
      coil_in      = coil_ff;
      valid_in     = valid_ff;
      spd_in       = spd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_req.start = 1'b0;
      div_req.num   = NUM_W'(cfg.spacing_um[gidx_ff]) * UM_TO_MM_SCALE;
      div_req.den   = gate_el;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               lvl_in   = req_tdata[4:0];
               tus_in   = req_tdata[36:5];
               tms_in   = req_tdata[68:37];
               valid_in = '0;
               for (int g = 0; g < NUM_GATES; g++) begin
                  spd_in[g] = '0;
               end
               state_in = ST_ARM;
            end
         end
         ST_ARM: begin
            arm_in = arm_new;
            if (elapsed_ms <= {16'd0, cfg.fire_window_ms}) begin
               coil_in = lowest_low;
            end else begin
               coil_in = '0;
               if (elapsed_ms >= {16'd0, cfg.cooldown_ms}) begin
                  arm_in = '0;
               end
            end
            gidx_in  = '0;
            state_in = lvl_ff[0] ? ST_GATE : ST_DONE;
         end
         ST_GATE: begin
            state_in = (gidx_ff == GIDX_W'(NUM_GATES - 1)) ? ST_DONE : ST_GATE;
            gidx_in  = gidx_ff + 1'b1;
            if (here_low && gate_start == '0 && !next_low) begin
               start_in[gidx_ff] = tus_ff;
            end
            if (next_low && gate_start != '0) begin
               start_in[gidx_ff] = '0;
               if (gate_el > 32'd1) begin
                  div_req.start = 1'b1;
                  gidx_in       = gidx_ff;
                  state_in      = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               spd_in[gidx_ff]   = div_rsp.quot;
               valid_in[gidx_ff] = 1'b1;
               gidx_in           = gidx_ff + 1'b1;
               state_in = (gidx_ff == GIDX_W'(NUM_GATES - 1)) ? ST_DONE : ST_GATE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, spd_ff[3], spd_ff[2], spd_ff[1], spd_ff[0],
                               valid_ff, coil_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gidx_ff      <= '0;
         arm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < NUM_GATES; g++) begin
            start_ff[g] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         gidx_ff      <= gidx_in;
         arm_ff       <= arm_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff      <= lvl_in;
      tus_ff      <= tus_in;
      tms_ff      <= tms_in;
      coil_ff     <= coil_in;
      valid_ff    <= valid_in;
      spd_ff      <= spd_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
